### design/pwrfd_pkg.sv
package pwrfd_pkg;

  localparam int FRAME_BITS = 24;
  localparam int KEY_BITS   = 4;
  localparam int CODE_BITS  = FRAME_BITS - KEY_BITS;
  localparam int COUNT_W    = $clog2(FRAME_BITS + 1);
  localparam int TIME_W     = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MAX  = 2'd3;

  localparam logic [TIME_W-1:0] SYNC_HIGH_MIN_RST = 16'd100;
  localparam logic [TIME_W-1:0] SYNC_HIGH_MAX_RST = 16'd2000;
  localparam logic [TIME_W-1:0] SYNC_LOW_MIN_RST  = 16'd5000;
  localparam logic [TIME_W-1:0] SYNC_LOW_MAX_RST  = 16'd15000;

  // What a rising edge turned out to be.
  typedef enum logic [1:0] {
    EV_BIT0,
    EV_BIT1,
    EV_RESTART,
    EV_SYNC
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } ev_word_t;

endpackage

### design/pulse_width_remote_frame_decoder_unit.sv
// Pulse-width remote frame decoder. Each input word is one line edge: the new
// level and the tick length of the period that ended. One edge is accepted per
// clock while the queue has room; the front stage classifies a rising edge in
// the cycle it arrives and hands the result to a two-entry event queue, and the
// back stage assembles bits and registers a frame word with out_valid once the
// closing sync event is popped from the queue. Sustained rate is one edge per
// cycle, set by the combinational classify compares and the queue, with stalls
// only from out_ready. The user must write the sync windows through cfg_we/
// cfg_index/cfg_data while the block is idle; the block does not enforce it.
module pulse_width_remote_frame_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pwrfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwrfd_pkg::TIME_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              new_level,
  input  logic [pwrfd_pkg::TIME_W-1:0]      duration,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic [pwrfd_pkg::CODE_BITS-1:0]   code,
  output logic [pwrfd_pkg::KEY_BITS-1:0]    key,
  output logic                              packet_seen
);
  import pwrfd_pkg::*;

  ev_word_t push;
  ev_word_t head;
  logic     q_full;
  logic     pop;

  pwrfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .new_level (new_level),
    .duration  (duration),
    .q_full    (q_full),
    .push      (push)
  );

  pwrfd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  pwrfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .code        (code),
    .key         (key),
    .packet_seen (packet_seen)
  );

endmodule

### design/pwrfd_front.sv
module pwrfd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pwrfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwrfd_pkg::TIME_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              new_level,
  input  logic [pwrfd_pkg::TIME_W-1:0]      duration,
  input  logic                              q_full,
  output pwrfd_pkg::ev_word_t               push
);
  import pwrfd_pkg::*;

  logic [TIME_W-1:0] sync_high_min;
  logic [TIME_W-1:0] sync_high_max;
  logic [TIME_W-1:0] sync_low_min;
  logic [TIME_W-1:0] sync_low_max;
  logic [TIME_W-1:0] high_time;
  logic              take;
  logic              is_sync;
  event_t            ev;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_high_min <= SYNC_HIGH_MIN_RST;
      sync_high_max <= SYNC_HIGH_MAX_RST;
      sync_low_min  <= SYNC_LOW_MIN_RST;
      sync_low_max  <= SYNC_LOW_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_HIGH_MIN: sync_high_min <= cfg_data;
        REG_SYNC_HIGH_MAX: sync_high_max <= cfg_data;
        REG_SYNC_LOW_MIN:  sync_low_min  <= cfg_data;
        REG_SYNC_LOW_MAX:  sync_low_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A falling edge ends a high period; its length is kept for the next pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      high_time <= '0;
    end else if (take && !new_level) begin
      high_time <= duration;
    end
  end

  assign is_sync = (high_time < duration) &&
                   (high_time > sync_high_min) && (high_time < sync_high_max) &&
                   (duration > sync_low_min) && (duration < sync_low_max);

  always_comb begin
    if (is_sync) begin
      ev = EV_SYNC;
    end else if (high_time == duration) begin
      ev = EV_RESTART;
    end else if (high_time > duration) begin
      ev = EV_BIT1;
    end else begin
      ev = EV_BIT0;
    end
  end

  assign push.valid = take && new_level;
  assign push.ev    = ev;

endmodule

### design/pwrfd_queue.sv
module pwrfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  pwrfd_pkg::ev_word_t  push,
  output logic                 full,
  output pwrfd_pkg::ev_word_t  head,
  input  logic                 pop
);
  import pwrfd_pkg::*;

  event_t     mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.ev    = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push.valid} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push.valid)
    else $error("event pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

### design/pwrfd_back.sv
module pwrfd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  pwrfd_pkg::ev_word_t               head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic [pwrfd_pkg::CODE_BITS-1:0]   code,
  output logic [pwrfd_pkg::KEY_BITS-1:0]    key,
  output logic                              packet_seen
);
  import pwrfd_pkg::*;

  logic [COUNT_W-1:0]    bit_count;
  logic [FRAME_BITS-1:0] frame_bits;
  logic [KEY_BITS-1:0]   last_key;
  logic                  seen_flag;
  logic                  full_frame;
  logic                  emit;
  logic                  key_ok;
  logic [KEY_BITS-1:0]   frame_key;

  // The output slot is free now or is being emptied this cycle.
  assign pop        = head.valid && (!out_valid || out_ready);
  assign full_frame = (bit_count == COUNT_W'(FRAME_BITS));
  assign emit       = pop && (head.ev == EV_SYNC) && full_frame;
  assign frame_key  = frame_bits[KEY_BITS-1:0];
  assign key_ok     = (frame_key != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count  <= '0;
      frame_bits <= '0;
      last_key   <= '0;
      seen_flag  <= 1'b0;
    end else if (pop) begin
      unique case (head.ev)
        EV_SYNC, EV_RESTART: begin
          bit_count <= '0;
        end
        EV_BIT0, EV_BIT1: begin
          // A bit past a full frame drops the frame instead of shifting.
          if (full_frame) begin
            bit_count <= '0;
          end else begin
            frame_bits <= {frame_bits[FRAME_BITS-2:0], (head.ev == EV_BIT1)};
            bit_count  <= bit_count + COUNT_W'(1);
          end
        end
        default: ;
      endcase
      if (emit && key_ok) begin
        last_key  <= frame_key;
        seen_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      accepted    <= key_ok;
      code        <= key_ok ? frame_bits[FRAME_BITS-1:KEY_BITS] : '0;
      key         <= key_ok ? frame_key : last_key;
      packet_seen <= seen_flag || key_ok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= COUNT_W'(FRAME_BITS))
    else $error("bit count beyond frame length");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (code == '0))
    else $error("rejected frame carries a code");

  a_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> packet_seen)
    else $error("accepted frame without seen flag");

endmodule
